FILE: rtl/mpsd_pkg.sv
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared constants, types and helpers of the multiplexed pot scanner with
// deadband: sizes, register indexes, divider and store request structs.
// ----------------------------------------------------------------------------
package mpsd_pkg;

	// Scanner geometry
	localparam int MUX_COUNT    = 4;
	localparam int POTS_PER_MUX = 16;
	localparam int SAMPLE_BITS  = 16;
	localparam int LANES        = 4;
	localparam int LIVE_LANES   = (MUX_COUNT < LANES) ? MUX_COUNT : LANES;
	localparam int STORE_DEPTH  = MUX_COUNT * POTS_PER_MUX;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CHAN_W       = $clog2(POTS_PER_MUX);
	localparam int LANE_W       = $clog2(LANES);
	localparam int LCNT_W       = LANE_W + 1;

	// Value formats
	localparam int SAMP_W = 16;
	localparam int VAL_W  = 17;
	localparam logic [VAL_W-1:0]  ONE_Q16      = 17'h10000;
	localparam logic [VAL_W-1:0]  HALF_Q16     = 17'h08000;
	localparam logic [SAMP_W-1:0] SAMPLE_MASK  = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam int                SAMPLE_SHIFT = SAMP_W - SAMPLE_BITS;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JITTER_THR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_RAD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MUXES = 3'd5;

	// Divider: 16 quotient bits, two per cycle
	localparam int QUO_W      = 16;
	localparam int DIV_CYCLES = QUO_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] num;
		logic [VAL_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  wdata;
	} store_req_t;

	// Distance from half scale within the radius
	function automatic logic is_centred(input logic [VAL_W-1:0] val,
	                                    input logic [15:0] radius);
		logic [VAL_W-1:0] offset;
		offset = (val >= HALF_Q16) ? (val - HALF_Q16) : (HALF_Q16 - val);
		return offset <= {1'b0, radius};
	endfunction

endpackage

FILE: rtl/mpsd_ram.sv
// ----------------------------------------------------------------------------
// mpsd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpsd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

FILE: rtl/mpsd_store.sv
// ----------------------------------------------------------------------------
// mpsd_store
// Pot value store: RAM plus one valid bit per entry, so that entries not
// written since reset read as zero.
// ----------------------------------------------------------------------------
module mpsd_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpsd_pkg::store_req_t                req,
	output logic [mpsd_pkg::VAL_W-1:0]          rdata
);

	logic [mpsd_pkg::STORE_DEPTH-1:0] valid_q;
	logic                             vld_s1;
	logic [mpsd_pkg::VAL_W-1:0]       ram_rdata;

	// Track written entries; sample the valid bit alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= valid_q[req.addr];
			end
		end
	end

	mpsd_ram #(
		.WIDTH (mpsd_pkg::VAL_W),
		.DEPTH (mpsd_pkg::STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.addr),
		.wdata (req.wdata),
		.re    (req.rd_en),
		.raddr (req.addr),
		.rdata (ram_rdata)
	);

	// Unwritten entries read as zero
	assign rdata = vld_s1 ? ram_rdata : '0;

endmodule

FILE: rtl/mpsd_div.sv
// ----------------------------------------------------------------------------
// mpsd_div
// Iterative restoring divider for (num << 16) / den, two quotient bits per
// cycle, saturating to 1.0. A zero divisor is taken as one.
// ----------------------------------------------------------------------------
module mpsd_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpsd_pkg::div_req_t   req,
	output mpsd_pkg::div_rsp_t   rsp
);

	logic                              run_q;
	logic                              done_q;
	logic [mpsd_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [mpsd_pkg::VAL_W-1:0]        rem_q;
	logic [mpsd_pkg::VAL_W-1:0]        den_q;
	logic [mpsd_pkg::QUO_W-1:0]        quo_q;
	logic                              sat_q;

	logic [mpsd_pkg::VAL_W-1:0]        den_eff;
	logic [mpsd_pkg::VAL_W:0]          t1;
	logic [mpsd_pkg::VAL_W:0]          t2;
	logic [mpsd_pkg::VAL_W-1:0]        r1;
	logic [mpsd_pkg::VAL_W-1:0]        r2;
	logic                              b1;
	logic                              b2;
	logic                              cnt_last;

	assign den_eff  = (req.den == '0) ? mpsd_pkg::VAL_W'(1) : req.den;
	assign cnt_last = cnt_q == mpsd_pkg::DIV_CNT_W'(mpsd_pkg::DIV_CYCLES - 1);

	// Two shift-compare-subtract steps
	always_comb begin
		t1 = {rem_q, 1'b0};
		b1 = t1 >= {1'b0, den_q};
		r1 = b1 ? mpsd_pkg::VAL_W'(t1 - {1'b0, den_q}) : t1[mpsd_pkg::VAL_W-1:0];
		t2 = {r1, 1'b0};
		b2 = t2 >= {1'b0, den_q};
		r2 = b2 ? mpsd_pkg::VAL_W'(t2 - {1'b0, den_q}) : t2[mpsd_pkg::VAL_W-1:0];
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !req.start && cnt_last;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: load operands, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= den_eff;
			sat_q <= req.num >= den_eff;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= r2;
			quo_q <= {quo_q[mpsd_pkg::QUO_W-3:0], b1, b2};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sat_q ? mpsd_pkg::ONE_Q16 : {1'b0, quo_q};

endmodule

FILE: rtl/mux_pot_scanner_deadband.sv
// ----------------------------------------------------------------------------
// mux_pot_scanner_deadband
// Scanner for multiplexed potentiometers: gain, floor, clamp, calibration
// divide and deadband update of a per-pot value store, one frame per item.
// ----------------------------------------------------------------------------
// Lanes run one after another through the store read port and the two-bit-per-cycle
// divider; in_stall holds off a new frame until the current result is loaded.
// A new frame is taken while the previous result still waits at the output.
// Reset: registers to defaults, channel counter to zero, pot store reads zero
// at once (per-entry valid bits); no clearing pass.
module mux_pot_scanner_deadband (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [mpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpsd_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input frame
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [15:0]                        sample_0,
	input  logic [15:0]                        sample_1,
	input  logic [15:0]                        sample_2,
	input  logic [15:0]                        sample_3,
	// result
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [3:0]                         scanned_channel,
	output logic [3:0]                         mux_address,
	output logic [16:0]                        value_0,
	output logic [16:0]                        value_1,
	output logic [16:0]                        value_2,
	output logic [16:0]                        value_3,
	output logic [3:0]                         changed_mask,
	output logic [3:0]                         centred_mask
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_COND,
		S_DIV,
		S_UPD,
		S_DONE
	} state_t;

	// Configuration registers
	logic [15:0] scale_gain_q;
	logic [16:0] floor_level_q;
	logic [16:0] full_scale_q;
	logic [16:0] jitter_thr_q;
	logic [15:0] centre_rad_q;
	logic [2:0]  active_muxes_q;

	// Sequencer state
	state_t                            state_q;
	logic [mpsd_pkg::CHAN_W-1:0]       cur_chan_q;
	logic [mpsd_pkg::CHAN_W-1:0]       chan_q;
	logic [mpsd_pkg::LANE_W-1:0]       lane_q;
	logic [mpsd_pkg::LCNT_W-1:0]       lanes_q;
	logic [mpsd_pkg::SAMP_W-1:0]       samp_q [mpsd_pkg::LANES];
	logic [mpsd_pkg::VAL_W-1:0]        val_q  [mpsd_pkg::LANES];
	logic [mpsd_pkg::LANES-1:0]        chg_q;
	logic [mpsd_pkg::LANES-1:0]        cen_q;
	logic [31:0]                       prod_s1;
	logic [mpsd_pkg::VAL_W-1:0]        old_q;

	// Result register
	logic                              out_valid_q;
	logic [3:0]                        scanned_q;
	logic [3:0]                        mux_addr_q;
	logic [mpsd_pkg::VAL_W-1:0]        out_val_q [mpsd_pkg::LANES];
	logic [3:0]                        changed_q;
	logic [3:0]                        centred_q;

	// Combinational
	logic [mpsd_pkg::SAMP_W-1:0]       in_samp [mpsd_pkg::LANES];
	logic [mpsd_pkg::LCNT_W-1:0]       lanes_clip;
	logic [mpsd_pkg::CHAN_W-1:0]       start_chan;
	logic [mpsd_pkg::CHAN_W-1:0]       next_chan;
	logic                              lane_live;
	logic                              lane_act;
	logic                              lane_last;
	logic [31:0]                       prod_c;
	logic [19:0]                       scaled;
	logic [mpsd_pkg::VAL_W-1:0]        cond_v;
	logic [mpsd_pkg::VAL_W-1:0]        store_rdata;
	logic [mpsd_pkg::VAL_W-1:0]        cond_val;
	logic [mpsd_pkg::VAL_W-1:0]        quo;
	logic [mpsd_pkg::VAL_W-1:0]        diff;
	logic                              upd_hit;
	logic [mpsd_pkg::VAL_W-1:0]        upd_val;
	logic                              div_busy_done;
	mpsd_pkg::div_req_t                div_req;
	mpsd_pkg::div_rsp_t                div_rsp;
	mpsd_pkg::store_req_t              store_req;

	// Hold configuration; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_gain_q   <= 16'd4096;
			floor_level_q  <= 17'd0;
			full_scale_q   <= 17'd65536;
			jitter_thr_q   <= 17'd655;
			centre_rad_q   <= 16'd0;
			active_muxes_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpsd_pkg::REG_SCALE_GAIN:   scale_gain_q   <= cfg_data[15:0];
				mpsd_pkg::REG_FLOOR_LEVEL:  floor_level_q  <= cfg_data;
				mpsd_pkg::REG_FULL_SCALE:   full_scale_q   <= cfg_data;
				mpsd_pkg::REG_JITTER_THR:   jitter_thr_q   <= cfg_data;
				mpsd_pkg::REG_CENTRE_RAD:   centre_rad_q   <= cfg_data[15:0];
				mpsd_pkg::REG_ACTIVE_MUXES: active_muxes_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign in_samp[0] = sample_0;
	assign in_samp[1] = sample_1;
	assign in_samp[2] = sample_2;
	assign in_samp[3] = sample_3;

	// Lane count, channel wrap, lane qualifiers
	assign lanes_clip = (int'(active_muxes_q) > mpsd_pkg::LIVE_LANES)
		? mpsd_pkg::LCNT_W'(mpsd_pkg::LIVE_LANES) : mpsd_pkg::LCNT_W'(active_muxes_q);
	assign start_chan = (int'(cur_chan_q) >= mpsd_pkg::POTS_PER_MUX) ? '0 : cur_chan_q;
	assign next_chan  = (int'(chan_q) == mpsd_pkg::POTS_PER_MUX - 1) ? '0 : chan_q + 1'b1;
	assign lane_live  = int'(lane_q) < mpsd_pkg::LIVE_LANES;
	assign lane_act   = {1'b0, lane_q} < lanes_q;
	assign lane_last  = lane_q == mpsd_pkg::LANE_W'(mpsd_pkg::LANES - 1);

	// Gain product, then floor and clamp
	assign prod_c = samp_q[lane_q] * scale_gain_q;
	assign scaled = prod_s1[31:12];
	always_comb begin
		if (scaled <= {3'b000, floor_level_q}) begin
			cond_v = '0;
		end else if (scaled > {3'b000, mpsd_pkg::ONE_Q16}) begin
			cond_v = mpsd_pkg::ONE_Q16;
		end else begin
			cond_v = scaled[mpsd_pkg::VAL_W-1:0];
		end
	end

	assign div_req.start = (state_q == S_COND) && lane_live && lane_act;
	assign div_req.num   = cond_v;
	assign div_req.den   = full_scale_q;

	mpsd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Deadband compare against the stored value
	assign quo     = div_rsp.quo;
	assign diff    = (quo >= old_q) ? (quo - old_q) : (old_q - quo);
	assign upd_hit = diff >= jitter_thr_q;
	assign upd_val = upd_hit ? quo : old_q;
	assign cond_val = lane_live ? store_rdata : '0;
	assign div_busy_done = div_rsp.done;

	assign store_req.rd_en = (state_q == S_MUL);
	assign store_req.wr_en = (state_q == S_UPD) && upd_hit;
	assign store_req.addr  = mpsd_pkg::ADDR_W'(
		mpsd_pkg::ADDR_W'(lane_q) * mpsd_pkg::ADDR_W'(mpsd_pkg::POTS_PER_MUX)
		+ mpsd_pkg::ADDR_W'(chan_q));
	assign store_req.wdata = quo;

	mpsd_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rdata  (store_rdata)
	);

	assign in_stall = (state_q != S_IDLE);

	// Sequencer: one lane at a time; active lanes read - condition - divide - write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_chan_q  <= '0;
			chan_q      <= '0;
			lane_q      <= '0;
			lanes_q     <= '0;
			chg_q       <= '0;
			cen_q       <= '0;
			prod_s1     <= '0;
			old_q       <= '0;
			out_valid_q <= 1'b0;
			scanned_q   <= '0;
			mux_addr_q  <= '0;
			changed_q   <= '0;
			centred_q   <= '0;
			for (int i = 0; i < mpsd_pkg::LANES; i++) begin
				samp_q[i]    <= '0;
				val_q[i]     <= '0;
				out_val_q[i] <= '0;
			end
		end else begin
			// drop the result once transferred, unless a new one is loaded
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						for (int i = 0; i < mpsd_pkg::LANES; i++) begin
							samp_q[i] <= (in_samp[i] & mpsd_pkg::SAMPLE_MASK)
								<< mpsd_pkg::SAMPLE_SHIFT;
						end
						chan_q  <= start_chan;
						lanes_q <= lanes_clip;
						lane_q  <= '0;
						chg_q   <= '0;
						cen_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_s1 <= prod_c;
					state_q <= S_COND;
				end
				S_COND: begin
					old_q <= store_rdata;
					if (lane_live && lane_act) begin
						state_q <= S_DIV;
					end else begin
						val_q[lane_q] <= cond_val;
						cen_q[lane_q] <= lane_live && mpsd_pkg::is_centred(cond_val, centre_rad_q);
						lane_q  <= lane_q + 1'b1;
						state_q <= lane_last ? S_DONE : S_MUL;
					end
				end
				S_DIV: begin
					if (div_busy_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					val_q[lane_q] <= upd_val;
					chg_q[lane_q] <= upd_hit;
					cen_q[lane_q] <= mpsd_pkg::is_centred(upd_val, centre_rad_q);
					lane_q  <= lane_q + 1'b1;
					state_q <= lane_last ? S_DONE : S_MUL;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						scanned_q   <= 4'(chan_q);
						mux_addr_q  <= 4'(next_chan);
						changed_q   <= chg_q;
						centred_q   <= cen_q;
						for (int i = 0; i < mpsd_pkg::LANES; i++) begin
							out_val_q[i] <= val_q[i];
						end
						cur_chan_q <= next_chan;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign scanned_channel = scanned_q;
	assign mux_address     = mux_addr_q;
	assign value_0         = out_val_q[0];
	assign value_1         = out_val_q[1];
	assign value_2         = out_val_q[2];
	assign value_3         = out_val_q[3];
	assign changed_mask    = changed_q;
	assign centred_mask    = centred_q;

	// A transferred frame starts its first lane
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MUL))
		else $error("frame transfer did not start a lane");

	// Divider completes only while the sequencer waits for it
	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider result arrived outside the wait state");

	// Each loaded result moves the channel counter on
	a_chan_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || !out_stall))
		|=> (out_valid_q && (cur_chan_q != $past(cur_chan_q))))
		else $error("channel counter did not advance with a result");

	// A store write belongs to a processed lane
	a_write_active_lane: assert property (@(posedge clk) disable iff (!arst_n)
		store_req.wr_en |-> (lane_live && lane_act))
		else $error("store written for an inactive lane");

endmodule

FILE: bench/mux_pot_scanner_deadband_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mux_pot_scanner_deadband_test
// Self-checking bench for the multiplexed pot scanner. A directed table walks
// the corner cases of gain, floor, calibration divide, deadband, centre flag
// and lane count; random phases then run near-steady pot movement with noise
// under many register settings. Results go against a scan-frame predictor or
// typed rows, with random gaps and stalls on both channels and one long hold.
// ----------------------------------------------------------------------------
module mux_pot_scanner_deadband_test;
	import mpsd_pkg::*;

	localparam int HOLD_CYCLES      = 400;
	localparam int DRAIN_CYCLES     = 64;
	localparam int STALL_LIMIT      = 4000;
	localparam int PHASES           = 12;
	localparam int FRAMES_PER_PHASE = 120;
	localparam int SQUEEZE_PHASE    = 5;
	localparam int REPORT_MAX       = 10;

	// Indexes outside the register map; writes to them must be ignored
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_B = 3'd7;

	// Register setting styles
	localparam int SET_TYPICAL = 0;
	localparam int SET_LOW     = 1;
	localparam int SET_HIGH    = 2;
	localparam int SET_WILD    = 3;

	typedef struct packed {
		logic [3:0]            chan;
		logic [3:0]            addr;
		logic [3:0][VAL_W-1:0] vals;
		logic [3:0]            changed;
		logic [3:0]            centred;
	} scan_result_t;

	typedef struct packed {
		logic                  is_write;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [3:0][15:0]      frame;
		logic                  typed;
		scan_result_t          want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [3:0][15:0]      frame;
	logic                  out_valid;
	logic                  out_stall;
	logic [3:0]            scanned_channel;
	logic [3:0]            mux_address;
	logic [VAL_W-1:0]      value_0, value_1, value_2, value_3;
	logic [3:0]            changed_mask;
	logic [3:0]            centred_mask;

	// Predictor state and register copies
	logic [VAL_W-1:0] pot_model [STORE_DEPTH];
	logic [3:0]       chan_model;
	logic [15:0]      gain_q12;
	logic [VAL_W-1:0] floor_q16;
	logic [VAL_W-1:0] fullscale_q16;
	logic [VAL_W-1:0] deadband_q16;
	logic [15:0]      radius_q16;
	logic [2:0]       lane_count;

	scan_result_t scan_q [$];
	stim_row_t    dir_rows [$];
	int           mismatches;
	int           quiet_cycles;
	logic         typed_pending;
	scan_result_t typed_result;
	logic         squeeze_req;
	logic [15:0]  last_samp [4][POTS_PER_MUX];
	int           chan_tx;

	mux_pot_scanner_deadband DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_0        (frame[0]),
		.sample_1        (frame[1]),
		.sample_2        (frame[2]),
		.sample_3        (frame[3]),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.scanned_channel (scanned_channel),
		.mux_address     (mux_address),
		.value_0         (value_0),
		.value_1         (value_1),
		.value_2         (value_2),
		.value_3         (value_3),
		.changed_mask    (changed_mask),
		.centred_mask    (centred_mask)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gain, floor, clamp, calibration divide and second clamp of one sample
	function automatic logic [VAL_W-1:0] calibrate(input logic [15:0] samp);
		logic [63:0] q, v, r, div;
		q = 64'(samp & SAMPLE_MASK) << SAMPLE_SHIFT;
		v = (q * 64'(gain_q12)) >> 12;
		div = (fullscale_q16 == '0) ? 64'd1 : 64'(fullscale_q16);
		if (v <= 64'(floor_q16)) v = 64'd0;
		if (v > 64'(ONE_Q16)) v = 64'(ONE_Q16);
		r = (v << 16) / div;
		if (r > 64'(ONE_Q16)) r = 64'(ONE_Q16);
		return r[VAL_W-1:0];
	endfunction

	// Apply one frame to the pot store and advance the channel
	function automatic scan_result_t scan_frame(input logic [3:0][15:0] f);
		scan_result_t     res;
		int               lanes;
		int               slot;
		logic [3:0]       chan;
		logic [VAL_W-1:0] fresh, held, diff, span;
		res = '0;
		chan = chan_model;
		if (chan >= POTS_PER_MUX) chan = '0;
		lanes = lane_count;
		if (lanes > LIVE_LANES) lanes = LIVE_LANES;
		for (int m = 0; m < LANES; m++) begin
			if (m < MUX_COUNT) begin
				slot = m * POTS_PER_MUX + chan;
				if (m < lanes) begin
					fresh = calibrate(f[m]);
					held = pot_model[slot];
					diff = (fresh >= held) ? fresh - held : held - fresh;
					if (diff >= deadband_q16) begin
						pot_model[slot] = fresh;
						res.changed[m] = 1'b1;
					end
				end
				res.vals[m] = pot_model[slot];
				span = (res.vals[m] >= HALF_Q16) ? res.vals[m] - HALF_Q16
				                                 : HALF_Q16 - res.vals[m];
				if (span <= {1'b0, radius_q16}) res.centred[m] = 1'b1;
			end
		end
		res.chan = chan;
		res.addr = (chan == POTS_PER_MUX - 1) ? 4'd0 : chan + 4'd1;
		chan_model = res.addr;
		return res;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// Track register writes, check results, predict accepted frames
	always @(posedge clk) begin : watch
		scan_result_t got;
		scan_result_t want;
		logic         moved;
		if (!arst_n) begin
			for (int k = 0; k < STORE_DEPTH; k++) pot_model[k] = '0;
			chan_model = '0;
			gain_q12 = 16'd4096;
			floor_q16 = '0;
			fullscale_q16 = ONE_Q16;
			deadband_q16 = 17'd655;
			radius_q16 = '0;
			lane_count = 3'd4;
			quiet_cycles = 0;
		end else begin
			moved = 1'b0;
			if (cfg_we) begin
				moved = 1'b1;
				case (cfg_index)
					REG_SCALE_GAIN:   gain_q12 = cfg_data[15:0];
					REG_FLOOR_LEVEL:  floor_q16 = cfg_data;
					REG_FULL_SCALE:   fullscale_q16 = cfg_data;
					REG_JITTER_THR:   deadband_q16 = cfg_data;
					REG_CENTRE_RAD:   radius_q16 = cfg_data[15:0];
					REG_ACTIVE_MUXES: lane_count = cfg_data[2:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got.chan = scanned_channel;
				got.addr = mux_address;
				got.vals = {value_3, value_2, value_1, value_0};
				got.changed = changed_mask;
				got.centred = centred_mask;
				if (scan_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result with nothing expected, channel %0d",
						         $time, scanned_channel);
				end else begin
					want = scan_q.pop_front();
					check_field("scanned_channel", want.chan, got.chan);
					check_field("mux_address", want.addr, got.addr);
					for (int m = 0; m < LANES; m++)
						check_field($sformatf("value_%0d", m), want.vals[m], got.vals[m]);
					check_field("changed_mask", want.changed, got.changed);
					check_field("centred_mask", want.centred, got.centred);
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				want = scan_frame(frame);
				if (typed_pending) want = typed_result;
				scan_q.push_back(want);
			end
			// Give up when the block stops moving
			if (moved) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("mux_pot_scanner_deadband verification failed");
					$finish;
				end
			end
		end
	end

	// Result stall: random bursts, plus one long hold on request
	initial begin : receiver
		int mode;
		int len;
		out_stall = 1'b0;
		forever begin
			if (squeeze_req) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				squeeze_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 9);
				len = $urandom_range(5, 60);
				repeat (len) begin
					@(negedge clk);
					if (mode < 3)
						out_stall <= 1'b0;
					else if (mode < 9)
						out_stall <= ($urandom_range(0, 3) == 0);
					else
						out_stall <= 1'b1;
				end
			end
		end
	end

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Pots mostly creep around their last position, with jumps and rails
	function automatic logic [3:0][15:0] wander_frame();
		logic [3:0][15:0] f;
		int pick;
		int level;
		for (int m = 0; m < 4; m++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				level = int'(last_samp[m][chan_tx]) + $urandom_range(0, 1600) - 800;
				if (level < 0) level = 0;
				if (level > 65535) level = 65535;
				f[m] = level[15:0];
			end else if (pick < 92) begin
				f[m] = 16'($urandom);
			end else begin
				f[m] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			last_samp[m][chan_tx] = f[m];
		end
		return f;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx,
	                                                      input int style);
		if (style == SET_WILD) return 17'($urandom);
		case (idx)
			REG_SCALE_GAIN:
				return (style == SET_LOW) ? 17'd0 : (style == SET_HIGH) ? 17'd65535
				       : 17'($urandom_range(3000, 8000));
			REG_FLOOR_LEVEL:
				return (style == SET_LOW) ? 17'd0 : (style == SET_HIGH) ? 17'd65536
				       : 17'($urandom_range(0, 2000));
			REG_FULL_SCALE:
				return (style == SET_LOW) ? 17'd1 : (style == SET_HIGH) ? 17'd65536
				       : 17'($urandom_range(40000, 65536));
			REG_JITTER_THR:
				return (style == SET_LOW) ? 17'd0 : (style == SET_HIGH) ? 17'd65536
				       : 17'($urandom_range(0, 2000));
			REG_CENTRE_RAD:
				return (style == SET_LOW) ? 17'd0 : (style == SET_HIGH) ? 17'd32768
				       : 17'($urandom_range(0, 4000));
			REG_ACTIVE_MUXES:
				return (style == SET_LOW) ? 17'd1 : (style == SET_HIGH) ? 17'd4
				       : 17'($urandom_range(1, 4));
			default:
				return '0;
		endcase
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.idx = idx;
		row.data = data;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_frame(input logic [3:0][15:0] f, input logic typed,
	                                  input scan_result_t want);
		stim_row_t row;
		row = '0;
		row.frame = f;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one frame, hold it until the transfer, then idle for the gap
	task automatic send_frame(input logic [3:0][15:0] f, input logic typed,
	                          input scan_result_t want, input int gap);
		@(negedge clk);
		in_valid <= 1'b1;
		frame <= f;
		typed_pending = typed;
		typed_result = want;
		do @(posedge clk); while (in_stall);
		chan_tx = (chan_tx + 1) % POTS_PER_MUX;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every result is back and the block is quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (scan_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [3:0][15:0] f;
		logic             busy;
		int               style;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		frame = '0;
		typed_pending = 1'b0;
		typed_result = '0;
		squeeze_req = 1'b0;
		mismatches = 0;
		chan_tx = 0;
		busy = 1'b0;
		for (int m = 0; m < 4; m++)
			for (int c = 0; c < POTS_PER_MUX; c++) last_samp[m][c] = '0;

		// Defaults straight after reset: rails and half scale are obvious
		add_frame({4{16'h0000}}, 1'b1, '{chan: 4'd0, addr: 4'd1,
		          vals: {4{17'd0}}, changed: 4'h0, centred: 4'h0});
		add_frame({4{16'hFFFF}}, 1'b1, '{chan: 4'd1, addr: 4'd2,
		          vals: {4{17'd65535}}, changed: 4'hF, centred: 4'h0});
		add_frame({4{16'h8000}}, 1'b1, '{chan: 4'd2, addr: 4'd3,
		          vals: {4{17'd32768}}, changed: 4'hF, centred: 4'hF});
		// Change below the deadband, then mixed lanes
		add_frame({4{16'h0100}}, 1'b0, '0);
		add_frame({16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000}, 1'b0, '0);
		// Gain extremes: saturate, then nothing through
		add_write(REG_SCALE_GAIN, 17'd65535);
		add_frame({16'h2000, 16'h0001, 16'hFFFF, 16'h1000}, 1'b0, '0);
		add_write(REG_SCALE_GAIN, 17'd0);
		add_frame({4{16'hFFFF}}, 1'b0, '0);
		// Floor: everything at or below, then right at the edge
		add_write(REG_SCALE_GAIN, 17'd4096);
		add_write(REG_FLOOR_LEVEL, 17'd65536);
		add_frame({4{16'hFFFF}}, 1'b0, '0);
		add_write(REG_FLOOR_LEVEL, 17'd32768);
		add_frame({16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF}, 1'b0, '0);
		// Zero divisor counts as one; then a half-scale divisor
		add_write(REG_FLOOR_LEVEL, 17'd0);
		add_write(REG_FULL_SCALE, 17'd0);
		add_frame({16'hFFFF, 16'h0000, 16'h0000, 16'h0001}, 1'b0, '0);
		add_write(REG_FULL_SCALE, 17'd32768);
		add_frame({16'hC000, 16'h8000, 16'h4000, 16'h0010}, 1'b0, '0);
		// No deadband updates every lane; full deadband almost never does
		add_write(REG_FULL_SCALE, 17'd65536);
		add_write(REG_JITTER_THR, 17'd0);
		add_frame({4{16'h1234}}, 1'b0, '0);
		add_write(REG_JITTER_THR, 17'd65536);
		add_frame({4{16'hFFFF}}, 1'b0, '0);
		// Centre radius at both ends
		add_write(REG_JITTER_THR, 17'd655);
		add_write(REG_CENTRE_RAD, 17'd32768);
		add_frame({16'h0000, 16'hFFFF, 16'h8000, 16'h3000}, 1'b0, '0);
		add_write(REG_CENTRE_RAD, 17'd100);
		add_frame({16'h8064, 16'h8065, 16'h7F9C, 16'h7F9B}, 1'b0, '0);
		// Lane count: none, oversized, partial
		add_write(REG_ACTIVE_MUXES, 17'd0);
		add_frame({4{16'hFFFF}}, 1'b0, '0);
		add_write(REG_ACTIVE_MUXES, 17'd7);
		add_frame({4{16'h6000}}, 1'b0, '0);
		add_write(REG_ACTIVE_MUXES, 17'd2);
		add_frame({4{16'hF000}}, 1'b0, '0);
		// Writes outside the map change nothing
		add_write(SPARE_REG_A, 17'h1FFFF);
		add_write(SPARE_REG_B, 17'h12345);
		add_frame({16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3}, 1'b0, '0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table; writes only once the block is idle
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_write) begin
				if (busy) settle();
				busy = 1'b0;
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want,
				           gap_len());
				busy = 1'b1;
			end
		end
		settle();

		// Random phases, each under a fresh register setting
		for (int p = 0; p < PHASES; p++) begin
			for (int r = 0; r <= int'(REG_ACTIVE_MUXES); r++) begin
				case (p)
					0: style = SET_TYPICAL;
					1: style = SET_HIGH;
					2: style = SET_LOW;
					3: style = SET_WILD;
					default: begin
						style = $urandom_range(0, 99);
						style = (style < 70) ? SET_TYPICAL : (style < 80) ? SET_LOW
						      : (style < 90) ? SET_HIGH : SET_WILD;
					end
				endcase
				write_reg(3'(r), pick_setting(3'(r), style));
			end
			// Hold the result side off while frames keep coming
			if (p == SQUEEZE_PHASE) squeeze_req = 1'b1;
			for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
				f = wander_frame();
				send_frame(f, 1'b0, '0, (p == SQUEEZE_PHASE) ? 0 : gap_len());
			end
			settle();
		end

		if (mismatches == 0 && scan_q.size() == 0)
			$display("mux_pot_scanner_deadband verification clean");
		else
			$display("mux_pot_scanner_deadband verification failed");
		$finish;
	end

endmodule
